[rtl/refcounted_inode_cache_table_macros.svh]
// Assertion macros shared by the inode cache RTL.
// Each use expects clk and rst_n in the enclosing module scope.
`ifndef REFCOUNTED_INODE_CACHE_TABLE_MACROS_SVH
`define REFCOUNTED_INODE_CACHE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RICT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RICT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rict_pkg.sv]
package rict_pkg;

    localparam int SLOT_W = 6;
    localparam int NUM_W  = 16;
    localparam int CNT_W  = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0] COUNT_ONE = 16'h0001;

    // Request command codes; code 3 is unused
    typedef enum logic [1:0] {
        CMD_GET  = 2'd0,
        CMD_PUT  = 2'd1,
        CMD_SYNC = 2'd2
    } command_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_ALLOC    = 3'd1,
        ST_FULL     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_RELEASED = 3'd4,
        ST_DECR     = 3'd5,
        ST_IDLE_ERR = 3'd6,
        ST_SYNC     = 3'd7
    } status_t;

    // Slot address source for table reads and writes
    typedef enum logic [1:0] {
        SEL_SCAN = 2'd0,
        SEL_IDX  = 2'd1,
        SEL_FREE = 2'd2
    } sel_t;

    // Reference count update
    typedef enum logic [1:0] {
        CNT_INC = 2'd0,
        CNT_DEC = 2'd1,
        CNT_ONE = 2'd2
    } cnt_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    addr_inc;
        logic    free_rec;
        logic    rd_en;
        logic    wr_num;
        logic    wr_cnt;
        logic    live_set;
        logic    live_clr;
        logic    out_load;
        sel_t    sel;
        cnt_op_t cnt_op;
        status_t status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic cur_live;
        logic match;
        logic cnt_max;
        logic cnt_one;
        logic put_bad;
        logic free_found;
        logic out_free;
    } sts_t;

endpackage

[rtl/rict_dpath.sv]
`include "refcounted_inode_cache_table_macros.svh"

module rict_dpath #(
    parameter int SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rict_pkg::cmd_t                cmd,
    output rict_pkg::sts_t                sts,
    input  logic [rict_pkg::NUM_W-1:0]    inode_number,
    input  logic [rict_pkg::SLOT_W-1:0]   slot_index,
    input  logic                          no_links,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [2:0]                    status,
    output logic [rict_pkg::SLOT_W-1:0]   slot,
    output logic [rict_pkg::NUM_W-1:0]    slot_inode,
    output logic                          free_on_disk,
    output logic                          last
);

    localparam int AW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW = rict_pkg::SLOT_W;
    localparam int NW = rict_pkg::NUM_W;
    localparam int CW = rict_pkg::CNT_W;

    // Table storage
    logic [NW-1:0] num_mem [SLOTS];
    logic [CW-1:0] cnt_mem [SLOTS];
    logic [SLOTS-1:0] live_reg;

    // Request and scan registers
    logic [NW-1:0] num_reg;
    logic [SW-1:0] idx_reg;
    logic          nolink_reg;
    logic [AW-1:0] addr_reg;
    logic [IW-1:0] free_reg;
    logic          free_found_reg;
    logic [NW-1:0] rd_num_reg;
    logic [CW-1:0] rd_cnt_reg;

    // Result register
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [SW-1:0] out_slot_reg;
    logic [NW-1:0] out_inode_reg;
    logic          out_free_reg;
    logic          out_last_reg;

    logic [IW-1:0] scan_ix;
    logic [IW-1:0] req_ix;
    logic [IW-1:0] tab_ix;
    logic [CW-1:0] cnt_wdata;
    logic          later_live;
    logic          out_free;
    logic [SW-1:0] res_slot;
    logic [NW-1:0] res_inode;
    logic          res_free;
    logic          res_last;

    assign scan_ix = addr_reg[IW-1:0];
    assign req_ix  = idx_reg[IW-1:0];

    // Table address select
    always_comb
    begin
        case (cmd.sel)
            rict_pkg::SEL_SCAN: tab_ix = scan_ix;
            rict_pkg::SEL_IDX:  tab_ix = req_ix;
            rict_pkg::SEL_FREE: tab_ix = free_reg;
            default:            tab_ix = scan_ix;
        endcase
    end

    // Count update value
    always_comb
    begin
        case (cmd.cnt_op)
            rict_pkg::CNT_INC: cnt_wdata = CW'(rd_cnt_reg + 1'b1);
            rict_pkg::CNT_DEC: cnt_wdata = CW'(rd_cnt_reg - 1'b1);
            rict_pkg::CNT_ONE: cnt_wdata = rict_pkg::COUNT_ONE;
            default:           cnt_wdata = rict_pkg::COUNT_ONE;
        endcase
    end

    // Table memories: one port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_num)
        begin
            num_mem[tab_ix] <= num_reg;
        end
        if (cmd.wr_cnt)
        begin
            cnt_mem[tab_ix] <= cnt_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_num_reg <= num_mem[tab_ix];
            rd_cnt_reg <= cnt_mem[tab_ix];
        end
    end

    // Live bits: set when a slot is claimed, cleared when its last reference is put
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (cmd.live_set)
        begin
            live_reg[tab_ix] <= 1'b1;
        end
        else if (cmd.live_clr)
        begin
            live_reg[tab_ix] <= 1'b0;
        end
    end

    // Scan pointer and first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.load_in)
        begin
            addr_reg       <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.addr_inc)
            begin
                addr_reg <= AW'(addr_reg + 1'b1);
            end
            if (cmd.free_rec && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Request capture and free slot number
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            num_reg    <= inode_number;
            idx_reg    <= slot_index;
            nolink_reg <= no_links;
        end
        if (cmd.free_rec && !free_found_reg)
        begin
            free_reg <= scan_ix;
        end
    end

    // Any live slot above the scan point
    always_comb
    begin
        later_live = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (AW'(j) > addr_reg)
            begin
                later_live = later_live | live_reg[j];
            end
        end
    end

    // Result fields by status
    always_comb
    begin
        res_slot  = SW'(scan_ix);
        res_inode = num_reg;
        res_free  = 1'b0;
        res_last  = 1'b1;
        case (cmd.status)
            rict_pkg::ST_HIT, rict_pkg::ST_OVERFLOW:
            begin
                res_slot = SW'(scan_ix);
            end
            rict_pkg::ST_ALLOC:
            begin
                res_slot = SW'(free_reg);
            end
            rict_pkg::ST_FULL:
            begin
                res_slot = '0;
            end
            rict_pkg::ST_RELEASED:
            begin
                res_slot  = idx_reg;
                res_inode = rd_num_reg;
                res_free  = nolink_reg;
            end
            rict_pkg::ST_DECR:
            begin
                res_slot  = idx_reg;
                res_inode = rd_num_reg;
            end
            rict_pkg::ST_IDLE_ERR:
            begin
                res_slot  = idx_reg;
                res_inode = '0;
            end
            rict_pkg::ST_SYNC:
            begin
                res_slot  = SW'(scan_ix);
                res_inode = rd_num_reg;
                res_last  = !later_live;
            end
            default:
            begin
                res_slot = SW'(scan_ix);
            end
        endcase
    end

    // Output register
    assign out_free = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.status;
            out_slot_reg   <= res_slot;
            out_inode_reg  <= res_inode;
            out_free_reg   <= res_free;
            out_last_reg   <= res_last;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign slot         = out_slot_reg;
    assign slot_inode   = out_inode_reg;
    assign free_on_disk = out_free_reg;
    assign last         = out_last_reg;

    // Status back to the controller
    assign sts.scan_done  = (addr_reg == AW'(SLOTS));
    assign sts.cur_live   = live_reg[scan_ix];
    assign sts.match      = (rd_num_reg == num_reg);
    assign sts.cnt_max    = (rd_cnt_reg == rict_pkg::COUNT_MAX);
    assign sts.cnt_one    = (rd_cnt_reg == rict_pkg::COUNT_ONE);
    assign sts.put_bad    = ({1'b0, idx_reg} >= 7'(SLOTS)) || !live_reg[req_ix];
    assign sts.free_found = free_found_reg;
    assign sts.out_free   = out_free;

    `RICT_ASSERT_NOW(a_addr_bound, 1'b1, addr_reg <= AW'(SLOTS), "scan pointer past table end")
    `RICT_ASSERT_NEXT(a_alloc_live, cmd.live_set, live_reg[$past(tab_ix)], "allocated slot not live")
    `RICT_ASSERT_NEXT(a_release_idle, cmd.live_clr, !live_reg[$past(tab_ix)], "released slot still live")

endmodule

[rtl/rict_ctrl.sv]
`include "refcounted_inode_cache_table_macros.svh"

module rict_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  logic [1:0]     command,
    output rict_pkg::cmd_t cmd,
    input  rict_pkg::sts_t sts
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_GSCAN = 8'b0000_0010,
        S_GCHK  = 8'b0000_0100,
        S_GEND  = 8'b0000_1000,
        S_PRD   = 8'b0001_0000,
        S_PCHK  = 8'b0010_0000,
        S_SSCAN = 8'b0100_0000,
        S_SEMIT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    case (command)
                        rict_pkg::CMD_GET:  state_next = S_GSCAN;
                        rict_pkg::CMD_PUT:  state_next = S_PRD;
                        rict_pkg::CMD_SYNC: state_next = S_SSCAN;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            // get: walk slots, read only live ones
            S_GSCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_GEND;
                end
                else if (sts.cur_live)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.sel    = rict_pkg::SEL_SCAN;
                    state_next = S_GCHK;
                end
                else
                begin
                    cmd.free_rec = 1'b1;
                    cmd.addr_inc = 1'b1;
                end
            end
            S_GCHK:
            begin
                if (sts.match)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.sel      = rict_pkg::SEL_SCAN;
                        if (sts.cnt_max)
                        begin
                            cmd.status = rict_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.status = rict_pkg::ST_HIT;
                            cmd.wr_cnt = 1'b1;
                            cmd.cnt_op = rict_pkg::CNT_INC;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = S_GSCAN;
                end
            end
            // get miss: claim the first free slot or report full
            S_GEND:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.free_found)
                    begin
                        cmd.status   = rict_pkg::ST_ALLOC;
                        cmd.sel      = rict_pkg::SEL_FREE;
                        cmd.wr_num   = 1'b1;
                        cmd.wr_cnt   = 1'b1;
                        cmd.cnt_op   = rict_pkg::CNT_ONE;
                        cmd.live_set = 1'b1;
                    end
                    else
                    begin
                        cmd.status = rict_pkg::ST_FULL;
                    end
                    state_next = S_IDLE;
                end
            end
            // put: check slot, then read its entry
            S_PRD:
            begin
                if (sts.put_bad)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.status   = rict_pkg::ST_IDLE_ERR;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.sel    = rict_pkg::SEL_IDX;
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.sel      = rict_pkg::SEL_IDX;
                    if (sts.cnt_one)
                    begin
                        cmd.status   = rict_pkg::ST_RELEASED;
                        cmd.live_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.status = rict_pkg::ST_DECR;
                        cmd.wr_cnt = 1'b1;
                        cmd.cnt_op = rict_pkg::CNT_DEC;
                    end
                    state_next = S_IDLE;
                end
            end
            // sync: one result per live slot
            S_SSCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.cur_live)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.sel    = rict_pkg::SEL_SCAN;
                    state_next = S_SEMIT;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end
            S_SEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.status   = rict_pkg::ST_SYNC;
                    cmd.addr_inc = 1'b1;
                    state_next   = S_SSCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `RICT_ASSERT_NOW(a_load_when_free, cmd.out_load, sts.out_free, "result loaded over a held result")
    `RICT_ASSERT_NOW(a_no_rd_wr_clash, cmd.rd_en, !cmd.wr_cnt && !cmd.wr_num, "table read and write together")

endmodule

[rtl/refcounted_inode_cache_table.sv]
// Sequencing: get scans the slots, reading each live one, and claims the first free slot on
//   a miss; put checks the slot, then reads its entry; sync emits one result per live slot.
// One item at a time: a new request is taken only while the controller is idle, and a
//   stalled output register holds the controller until it drains.
// Reset clears all live bits and the control state; held inode numbers and counts are
//   unknown until a slot is claimed.
module refcounted_inode_cache_table #(
    parameter int SLOTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  command,
    input  logic [rict_pkg::NUM_W-1:0]  inode_number,
    input  logic [rict_pkg::SLOT_W-1:0] slot_index,
    input  logic                        no_links,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [2:0]                  status,
    output logic [rict_pkg::SLOT_W-1:0] slot,
    output logic [rict_pkg::NUM_W-1:0]  slot_inode,
    output logic                        free_on_disk,
    output logic                        last
);

    rict_pkg::cmd_t cmd;
    rict_pkg::sts_t sts;

    rict_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .cmd       (cmd),
        .sts       (sts)
    );

    rict_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .inode_number (inode_number),
        .slot_index   (slot_index),
        .no_links     (no_links),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .slot         (slot),
        .slot_inode   (slot_inode),
        .free_on_disk (free_on_disk),
        .last         (last)
    );

endmodule

[sim/tb_refcounted_inode_cache_table.sv]
`timescale 1ns / 100ps

module tb_refcounted_inode_cache_table;

    localparam int SLOTS = 64;
    localparam int NW = rict_pkg::NUM_W;
    localparam int SW = rict_pkg::SLOT_W;
    localparam int CW = rict_pkg::CNT_W;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result as it should leave the block
    typedef struct {
        rict_pkg::status_t st;
        logic [SW-1:0]     slot;
        logic [NW-1:0]     ino;
        logic              free_disk;
        logic              last;
    } reply_t;

    // Mirror of the slot table plus the replies still owed by the block
    class inode_table_scoreboard;
        logic [CW-1:0] refs [SLOTS];
        logic [NW-1:0] held [SLOTS];
        reply_t pending_replies [$];
        int errors;

        function new();
            foreach (refs[i])
            begin
                refs[i] = '0;
                held[i] = '0;
            end
            errors = 0;
        endfunction

        function void queue_reply(rict_pkg::status_t s, int sl, logic [NW-1:0] ino, logic fd,
                                  logic lst);
            reply_t r;
            r.st        = s;
            r.slot      = sl[SW-1:0];
            r.ino       = ino;
            r.free_disk = fd;
            r.last      = lst;
            pending_replies.push_back(r);
        endfunction

        function int live_count();
            int n;
            n = 0;
            for (int i = 0; i < SLOTS; i++)
                if (refs[i] != 0) n++;
            return n;
        endfunction

        function int pick_live();
            int live_slots [$];
            for (int i = 0; i < SLOTS; i++)
                if (refs[i] != 0) live_slots.push_back(i);
            if (live_slots.size() == 0) return -1;
            return live_slots[$urandom_range(live_slots.size() - 1)];
        endfunction

        // Update the table for an accepted item and queue the replies it owes
        function void apply_request(logic [1:0] cmd, logic [NW-1:0] ino,
                                    logic [SW-1:0] idx, logic nl);
            int hit;
            int free_slot;
            int total;
            int k;
            case (cmd)
                rict_pkg::CMD_GET:
                begin
                    hit = -1;
                    free_slot = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (hit < 0 && refs[i] != 0 && held[i] == ino) hit = i;
                        if (free_slot < 0 && refs[i] == 0) free_slot = i;
                    end
                    if (hit >= 0)
                    begin
                        if (refs[hit] == rict_pkg::COUNT_MAX)
                            queue_reply(rict_pkg::ST_OVERFLOW, hit, ino, 1'b0, 1'b1);
                        else
                        begin
                            refs[hit] = refs[hit] + 1'b1;
                            queue_reply(rict_pkg::ST_HIT, hit, ino, 1'b0, 1'b1);
                        end
                    end
                    else if (free_slot >= 0)
                    begin
                        held[free_slot] = ino;
                        refs[free_slot] = rict_pkg::COUNT_ONE;
                        queue_reply(rict_pkg::ST_ALLOC, free_slot, ino, 1'b0, 1'b1);
                    end
                    else
                        queue_reply(rict_pkg::ST_FULL, 0, ino, 1'b0, 1'b1);
                end
                rict_pkg::CMD_PUT:
                begin
                    if (int'(idx) >= SLOTS || refs[idx] == 0)
                        queue_reply(rict_pkg::ST_IDLE_ERR, int'(idx), '0, 1'b0, 1'b1);
                    else if (refs[idx] == rict_pkg::COUNT_ONE)
                    begin
                        refs[idx] = '0;
                        queue_reply(rict_pkg::ST_RELEASED, int'(idx), held[idx], nl, 1'b1);
                    end
                    else
                    begin
                        refs[idx] = refs[idx] - 1'b1;
                        queue_reply(rict_pkg::ST_DECR, int'(idx), held[idx], 1'b0, 1'b1);
                    end
                end
                rict_pkg::CMD_SYNC:
                begin
                    total = live_count();
                    k = 0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (refs[i] != 0)
                        begin
                            k++;
                            queue_reply(rict_pkg::ST_SYNC, i, held[i], 1'b0, k == total);
                        end
                    end
                end
                default: ;  // unused code: nothing happens
            endcase
        endfunction

        function void report_field(string field, int want, int got);
            errors++;
            $display("ERROR %0t: %s expected %0h got %0h", $time, field, want, got);
        endfunction

        // Compare one accepted result with the oldest owed reply
        function void check_result(logic [2:0] st, logic [SW-1:0] sl,
                                   logic [NW-1:0] ino, logic fd, logic lst);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("ERROR %0t: unexpected result status %0h slot %0h inode %0h",
                         $time, st, sl, ino);
                return;
            end
            want = pending_replies.pop_front();
            if (st !== want.st)
                report_field("status", int'(want.st), int'(st));
            if (sl !== want.slot)
                report_field("slot", int'(want.slot), int'(sl));
            if (ino !== want.ino)
                report_field("slot_inode", int'(want.ino), int'(ino));
            if (fd !== want.free_disk)
                report_field("free_on_disk", int'(want.free_disk), int'(fd));
            if (lst !== want.last)
                report_field("last", int'(want.last), int'(lst));
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    logic [1:0]    command;
    logic [NW-1:0] inode_number;
    logic [SW-1:0] slot_index;
    logic          no_links;
    logic          rsp_valid;
    logic          rsp_stall;
    logic [2:0]    status;
    logic [SW-1:0] slot;
    logic [NW-1:0] slot_inode;
    logic          free_on_disk;
    logic          last;

    inode_table_scoreboard sb;
    bit send_idle;
    bit recv_idle;
    int stall_left;

    refcounted_inode_cache_table #(.SLOTS(SLOTS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .inode_number (inode_number),
        .slot_index   (slot_index),
        .no_links     (no_links),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .slot         (slot),
        .slot_inode   (slot_inode),
        .free_on_disk (free_on_disk),
        .last         (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side back-pressure: mostly short stalls, a few long ones
    initial
    begin
        rsp_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall = 1'b1;
                stall_left--;
            end
            else if (recv_idle && $urandom_range(99) < 20)
            begin
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
                rsp_stall = 1'b1;
            end
            else
                rsp_stall = 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && sb != null && rsp_valid && !rsp_stall)
            sb.check_result(status, slot, slot_inode, free_on_disk, last);
    end

    // Random field values at the field widths
    function automatic logic [NW-1:0] rand_ino();
        return NW'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [SW-1:0] rand_idx();
        return SW'($urandom_range(63));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic int pick_gap();
        int r;
        if (!send_idle) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item at the falling edge and hold it until taken
    task automatic send_item(input logic [1:0] cmd, input logic [NW-1:0] ino,
                             input logic [SW-1:0] idx, input logic nl);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command      = cmd;
        inode_number = ino;
        slot_index   = idx;
        no_links     = nl;
        req_valid    = 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.apply_request(cmd, ino, idx, nl);
        @(negedge clk);
    endtask

    task automatic wait_for_replies();
        req_valid = 1'b0;
        while (sb.pending_replies.size() != 0) @(negedge clk);
    endtask

    task automatic run_directed();
        send_item(rict_pkg::CMD_SYNC, 16'h0000, 6'd0,  1'b0);  // empty table: no result
        send_item(CMD_UNUSED,         16'hFFFF, 6'd63, 1'b1);  // ignored code
        send_item(rict_pkg::CMD_PUT,  16'h0000, 6'd0,  1'b1);  // put on a free slot
        send_item(rict_pkg::CMD_PUT,  16'hFFFF, 6'd63, 1'b0);
        send_item(rict_pkg::CMD_GET,  16'h0000, 6'd63, 1'b1);  // claims slot 0
        send_item(rict_pkg::CMD_GET,  16'hFFFF, 6'd0,  1'b0);  // claims slot 1
        send_item(rict_pkg::CMD_GET,  16'h0000, 6'd0,  1'b0);  // hit
        send_item(rict_pkg::CMD_GET,  16'hFFFF, 6'd63, 1'b1);  // hit
        send_item(rict_pkg::CMD_PUT,  16'h0000, 6'd0,  1'b1);  // decrement, no disk free
        send_item(rict_pkg::CMD_PUT,  16'hFFFF, 6'd0,  1'b1);  // last ref, disk free
        send_item(rict_pkg::CMD_GET,  16'hA5A5, 6'd21, 1'b0);  // reuses lowest free slot
        send_item(rict_pkg::CMD_SYNC, 16'h5A5A, 6'd42, 1'b1);
        send_item(rict_pkg::CMD_PUT,  16'h0000, 6'd1,  1'b0);
        send_item(rict_pkg::CMD_PUT,  16'h0000, 6'd1,  1'b0);  // last ref, links remain
        send_item(rict_pkg::CMD_PUT,  16'h0000, 6'd1,  1'b1);  // now idle
        send_item(rict_pkg::CMD_GET,  16'h5A5A, 6'd0,  1'b1);
        send_item(rict_pkg::CMD_PUT,  16'h0000, 6'd63, 1'b1);
        send_item(rict_pkg::CMD_SYNC, 16'hFFFF, 6'd63, 1'b0);
        send_item(CMD_UNUSED,         16'h0000, 6'd0,  1'b0);
    endtask

    // Mixed traffic over a small set of numbers so that hits are common
    task automatic random_mix(input int n, input int get_pct, input int put_pct,
                              input int sync_pct);
        logic [NW-1:0] pool [16];
        int r;
        int live;
        foreach (pool[i]) pool[i] = rand_ino();
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < get_pct)
            begin
                if ($urandom_range(9) == 0)
                    send_item(rict_pkg::CMD_GET, rand_ino(), rand_idx(), rand_bit());
                else
                    send_item(rict_pkg::CMD_GET, pool[$urandom_range(15)], rand_idx(),
                              rand_bit());
            end
            else if (r < get_pct + put_pct)
            begin
                live = sb.pick_live();
                if (live >= 0 && $urandom_range(9) != 0)
                    send_item(rict_pkg::CMD_PUT, rand_ino(), live[SW-1:0], rand_bit());
                else
                    send_item(rict_pkg::CMD_PUT, rand_ino(), rand_idx(), rand_bit());
            end
            else if (r < get_pct + put_pct + sync_pct)
                send_item(rict_pkg::CMD_SYNC, rand_ino(), rand_idx(), rand_bit());
            else
                send_item(CMD_UNUSED, rand_ino(), rand_idx(), rand_bit());
        end
    endtask

    // Claim every slot, then hit the full table and list it
    task automatic fill_table();
        while (sb.live_count() < SLOTS)
            send_item(rict_pkg::CMD_GET, rand_ino(), rand_idx(), rand_bit());
        repeat (3)
            send_item(rict_pkg::CMD_GET, rand_ino(), rand_idx(), rand_bit());
        send_item(rict_pkg::CMD_GET, sb.held[$urandom_range(SLOTS - 1)], rand_idx(),
                  rand_bit());
        send_item(rict_pkg::CMD_SYNC, rand_ino(), rand_idx(), rand_bit());
    endtask

    task automatic release_all();
        for (int i = 0; i < SLOTS; i++)
            while (sb.refs[i] != 0)
                send_item(rict_pkg::CMD_PUT, rand_ino(), i[SW-1:0], rand_bit());
    endtask

    // Take and drop several references on one slot; the table is empty on entry
    task automatic reuse_one_slot();
        logic [NW-1:0] ino;
        ino = rand_ino();
        repeat (5)
            send_item(rict_pkg::CMD_GET, ino, rand_idx(), rand_bit());
        send_item(rict_pkg::CMD_SYNC, ino, 6'd0, 1'b0);
        repeat (6)
            send_item(rict_pkg::CMD_PUT, ino, 6'd0, 1'b1);  // last one finds the slot idle
        send_item(rict_pkg::CMD_GET, ino, 6'd0, 1'b0);     // claims slot 0 again
        send_item(rict_pkg::CMD_SYNC, ino, 6'd0, 1'b0);
    endtask

    // Stimulus
    initial
    begin
        sb = new();
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        command      = rict_pkg::CMD_GET;
        inode_number = '0;
        slot_index   = '0;
        no_links     = 1'b0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        random_mix(60, 50, 35, 10);
        // hold the sender until the block has handed back everything
        wait_for_replies();

        send_idle = 1'b0;
        recv_idle = 1'b0;
        fill_table();

        send_idle = 1'b1;
        recv_idle = 1'b1;
        random_mix(60, 30, 55, 10);
        random_mix(30, 55, 30, 10);
        release_all();
        wait_for_replies();

        send_idle = 1'b0;
        recv_idle = 1'b0;
        reuse_one_slot();

        wait_for_replies();
        repeat (2 * SLOTS + 8) @(negedge clk);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
